/* src/msf_pkg.sv */
// shared types, constants and codes for the scalarizing fitness unit
`timescale 1ns / 1ps
`default_nettype none
package msf_pkg;

    localparam int MAX_OBJECTIVES = 8;
    localparam int CNT_W = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;
    localparam int LIM_OBJ = (MAX_OBJECTIVES < 8) ? MAX_OBJECTIVES : 8;

    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam logic [16:0] TCH_ZERO_WEIGHT = 17'd7;
    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
    localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

    // request modes
    localparam logic [1:0] MODE_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_IDEAL = 2'd1;
    localparam logic [1:0] MODE_OBJ = 2'd2;

    // methods
    localparam logic [1:0] METH_WSUM = 2'd0;
    localparam logic [1:0] METH_TCH = 2'd1;

    // register indexes
    localparam logic [1:0] REG_METHOD = 2'd0;
    localparam logic [1:0] REG_ADAPT = 2'd1;
    localparam logic [1:0] REG_NUM_OBJ = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] index;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] scalar_fitness;
        logic saturated;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADAPT,
        S_MUL,
        S_ACC,
        S_MUL2,
        S_ACC2,
        S_NORM_START,
        S_NORM_WAIT,
        S_D1_START,
        S_D1_WAIT,
        S_Q_MUL,
        S_Q_START,
        S_Q_WAIT,
        S_P_CHK,
        S_P_ACC,
        S_D2_START,
        S_D2_WAIT,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

/* src/moead_scalarizing_fitness_unit.sv */
// scalarizing fitness unit: storage, sequencer and result register
// weight and ideal requests are written in idle; an objective is stored and, with adaptation, updates the ideal
// the last objective then holds the block: weighted sum and tchebycheff multiply and accumulate per objective,
// pbi: sums, weight squares, norm root, d1 divide, a q divide and square per objective, d2 root, out
// all methods share one registered multiplier; only one request is worked on at a time
// rst_n clears control, the registers and the ideal point; weights and objectives start unset
`timescale 1ns / 1ps
`default_nettype none
module moead_scalarizing_fitness_unit
    import msf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire req_t       req,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output rsp_t            rsp,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [3:0] cfg_data
);

    // configuration registers
    logic [1:0] method_reg;
    logic       adapt_reg;
    logic [3:0] num_obj_reg;

    // per-index storage
    logic [16:0]        weight_mem [MAX_OBJECTIVES];
    logic signed [31:0] ideal_mem  [MAX_OBJECTIVES];
    logic signed [31:0] obj_mem    [MAX_OBJECTIVES];

    state_t state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [63:0]        w2_reg, w2_next;
    logic [31:0]        norm_reg, norm_next;
    logic [63:0]        d1_reg, d1_next;
    logic [63:0]        q_reg, q_next;
    logic [63:0]        sq_reg, sq_next;
    logic               big_reg, big_next;
    logic signed [63:0] res_reg, res_next;
    logic signed [31:0] val_reg, val_next;
    logic               last_reg, last_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    // write ports
    logic               w_we, i_we, o_we;
    logic [CNT_W-1:0]   w_addr, i_addr, o_addr;
    logic [16:0]        w_data;
    logic signed [31:0] i_data, o_data;

    // shared units
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic               dv_start, dv_done;
    logic [63:0]        dv_dividend, dv_quot;
    logic               sq_start, sq_done;
    logic [63:0]        sq_x;
    logic [31:0]        sq_root;

    // datapath helpers
    logic [3:0]         n_eff;
    logic               is_last_cnt;
    logic [16:0]        rd_w;
    logic signed [31:0] rd_ideal, rd_obj;
    logic signed [32:0] d_val;
    logic [16:0]        w_tch;
    logic signed [63:0] prod64, abs_prod, acc_new, abs_acc;
    logic signed [33:0] p_val;
    logic [33:0]        ap;
    logic [63:0]        sq_sum;
    logic [16:0]        w_clamped;
    logic signed [63:0] fin_val;
    logic               fin_sat;

    msf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    msf_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
        .divisor(norm_reg), .done(dv_done), .quotient(dv_quot)
    );

    msf_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .x(sq_x),
        .done(sq_done), .root(sq_root)
    );

    // effective vector length, clamped to 2..limit
    always_comb
    begin
        if (num_obj_reg < 4'd2)
            n_eff = 4'd2;
        else if (32'(num_obj_reg) > LIM_OBJ)
            n_eff = 4'(LIM_OBJ);
        else
            n_eff = num_obj_reg;
    end

    assign is_last_cnt = (32'(cnt_reg) == 32'(n_eff) - 1);

    assign rd_w = weight_mem[cnt_reg];
    assign rd_ideal = ideal_mem[cnt_reg];
    assign rd_obj = obj_mem[cnt_reg];
    assign d_val = 33'(rd_obj) - 33'(rd_ideal);
    // tiny stand-in weight so a zero weight still ranks by distance
    assign w_tch = (rd_w == 17'd0) ? TCH_ZERO_WEIGHT : rd_w;

    assign prod64 = mul_p[63:0];
    assign abs_prod = prod64[63] ? -prod64 : prod64;
    assign abs_acc = acc_reg[63] ? -acc_reg : acc_reg;
    assign p_val = 34'(d_val) - $signed({1'b0, q_reg[32:0]});
    assign ap = p_val[33] ? 34'(-p_val) : 34'(p_val);
    assign sq_sum = sq_reg + prod64;

    // per-method accumulation step
    always_comb
    begin
        case (method_reg)
            METH_TCH:
                acc_new = (abs_prod > acc_reg) ? abs_prod : acc_reg;
            default:
                acc_new = acc_reg + prod64;
        endcase
    end

    // weight clamp to 0..one
    always_comb
    begin
        if (req.value < 32'sd0)
            w_clamped = 17'd0;
        else if (req.value > $signed({15'd0, WEIGHT_ONE}))
            w_clamped = WEIGHT_ONE;
        else
            w_clamped = req.value[16:0];
    end

    // final saturation
    always_comb
    begin
        fin_val = res_reg;
        fin_sat = 1'b0;
        if (big_reg)
        begin
            fin_val = SAT_MAX;
            fin_sat = 1'b1;
        end
        else if (res_reg > SAT_MAX)
        begin
            fin_val = SAT_MAX;
            fin_sat = 1'b1;
        end
        else if (res_reg < SAT_MIN)
        begin
            fin_val = SAT_MIN;
            fin_sat = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        w2_next = w2_reg;
        norm_next = norm_reg;
        d1_next = d1_reg;
        q_next = q_reg;
        sq_next = sq_reg;
        big_next = big_reg;
        res_next = res_reg;
        val_next = val_reg;
        last_next = last_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;
        w_we = 1'b0;
        i_we = 1'b0;
        o_we = 1'b0;
        w_addr = CNT_W'(req.index);
        i_addr = CNT_W'(req.index);
        o_addr = CNT_W'(req.index);
        w_data = w_clamped;
        i_data = req.value;
        o_data = req.value;
        mul_a = 33'(rd_obj);
        mul_b = $signed({15'd0, rd_w});
        dv_start = 1'b0;
        dv_dividend = abs_acc + 64'(norm_reg >> 1);
        sq_start = 1'b0;
        sq_x = w2_reg;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.mode)
                        MODE_WEIGHT:
                            w_we = (32'(req.index) < MAX_OBJECTIVES);
                        MODE_IDEAL:
                            i_we = (32'(req.index) < MAX_OBJECTIVES);
                        MODE_OBJ:
                        begin
                            if ({1'b0, req.index} < n_eff)
                            begin
                                o_we = 1'b1;
                                val_next = req.value;
                                last_next = ({1'b0, req.index} == n_eff - 4'd1);
                                cnt_next = CNT_W'(req.index);
                                if (adapt_reg)
                                    state_next = S_ADAPT;
                                else if ({1'b0, req.index} == n_eff - 4'd1)
                                begin
                                    cnt_next = '0;
                                    acc_next = '0;
                                    w2_next = '0;
                                    sq_next = '0;
                                    big_next = 1'b0;
                                    state_next = S_MUL;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_ADAPT:
            begin
                // ideal coordinate follows the smallest objective seen
                i_addr = cnt_reg;
                i_data = val_reg;
                i_we = (val_reg < rd_ideal);
                if (last_reg)
                begin
                    cnt_next = '0;
                    acc_next = '0;
                    w2_next = '0;
                    sq_next = '0;
                    big_next = 1'b0;
                    state_next = S_MUL;
                end
                else
                    state_next = S_IDLE;
            end

            S_MUL:
            begin
                case (method_reg)
                    METH_WSUM:
                    begin
                        mul_a = 33'(rd_obj);
                        mul_b = $signed({15'd0, rd_w});
                    end
                    METH_TCH:
                    begin
                        mul_a = d_val;
                        mul_b = $signed({15'd0, w_tch});
                    end
                    default:
                    begin
                        mul_a = d_val;
                        mul_b = $signed({15'd0, rd_w});
                    end
                endcase
                state_next = S_ACC;
            end

            S_ACC:
            begin
                acc_next = acc_new;
                if (method_reg == METH_WSUM || method_reg == METH_TCH)
                begin
                    if (is_last_cnt)
                    begin
                        res_next = (acc_new + ROUND_HALF) >>> 16;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        state_next = S_MUL;
                    end
                end
                else
                    state_next = S_MUL2;
            end

            S_MUL2:
            begin
                mul_a = $signed({16'd0, rd_w});
                mul_b = $signed({15'd0, rd_w});
                state_next = S_ACC2;
            end

            S_ACC2:
            begin
                w2_next = w2_reg + prod64;
                if (is_last_cnt)
                    state_next = S_NORM_START;
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    state_next = S_MUL;
                end
            end

            S_NORM_START:
            begin
                sq_x = w2_reg;
                sq_start = 1'b1;
                state_next = S_NORM_WAIT;
            end

            S_NORM_WAIT:
            begin
                if (sq_done)
                begin
                    norm_next = sq_root;
                    cnt_next = '0;
                    if (sq_root == 32'd0)
                    begin
                        // all weights zero: no projection
                        d1_next = '0;
                        state_next = S_Q_MUL;
                    end
                    else
                        state_next = S_D1_START;
                end
            end

            S_D1_START:
            begin
                dv_dividend = abs_acc + 64'(norm_reg >> 1);
                dv_start = 1'b1;
                state_next = S_D1_WAIT;
            end

            S_D1_WAIT:
            begin
                if (dv_done)
                begin
                    d1_next = dv_quot;
                    if ($signed(dv_quot) > SAT_MAX || dv_quot[63])
                    begin
                        big_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_Q_MUL;
                end
            end

            S_Q_MUL:
            begin
                mul_a = $signed({1'b0, d1_reg[31:0]});
                mul_b = $signed({15'd0, rd_w});
                if (norm_reg == 32'd0)
                begin
                    q_next = '0;
                    state_next = S_P_CHK;
                end
                else
                    state_next = S_Q_START;
            end

            S_Q_START:
            begin
                dv_dividend = prod64 + 64'(norm_reg >> 1);
                dv_start = 1'b1;
                state_next = S_Q_WAIT;
            end

            S_Q_WAIT:
            begin
                if (dv_done)
                begin
                    q_next = dv_quot;
                    state_next = S_P_CHK;
                end
            end

            S_P_CHK:
            begin
                mul_a = $signed({2'b0, ap[30:0]});
                mul_b = $signed({1'b0, ap[30:0]});
                // perpendicular component too large to square
                if (ap[33:31] != 3'd0)
                begin
                    big_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_P_ACC;
            end

            S_P_ACC:
            begin
                sq_next = sq_sum;
                if (sq_sum[63:62] != 2'd0)
                begin
                    big_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (is_last_cnt)
                    state_next = S_D2_START;
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    state_next = S_Q_MUL;
                end
            end

            S_D2_START:
            begin
                sq_x = sq_reg;
                sq_start = 1'b1;
                state_next = S_D2_WAIT;
            end

            S_D2_WAIT:
            begin
                if (sq_done)
                begin
                    res_next = $signed(d1_reg + (64'(sq_root) << 2) + 64'(sq_root));
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.scalar_fitness = fin_val[31:0];
                    rsp_next.saturated = fin_sat;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            method_reg <= 2'd0;
            adapt_reg <= 1'b0;
            num_obj_reg <= 4'd2;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_METHOD:  method_reg <= cfg_data[1:0];
                    REG_ADAPT:   adapt_reg <= cfg_data[0];
                    REG_NUM_OBJ: num_obj_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        w2_reg <= w2_next;
        norm_reg <= norm_next;
        d1_reg <= d1_next;
        q_reg <= q_next;
        sq_reg <= sq_next;
        big_reg <= big_next;
        res_reg <= res_next;
        val_reg <= val_next;
        last_reg <= last_next;
        rsp_reg <= rsp_next;
        if (w_we)
            weight_mem[w_addr] <= w_data;
        if (o_we)
            obj_mem[o_addr] <= o_data;
    end

    // ideal point resets to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_OBJECTIVES; k++)
                ideal_mem[k] <= '0;
        end
        else if (i_we)
            ideal_mem[i_addr] <= i_data;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

`ifndef ASSERT_OFF
    a_sqrt_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_NORM_WAIT || state_reg == S_D2_WAIT))
        else $error("root finished outside a wait state");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        dv_done |-> (state_reg == S_D1_WAIT || state_reg == S_Q_WAIT))
        else $error("division finished outside a wait state");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.saturated) |->
            (rsp.scalar_fitness == 32'sh7fffffff || rsp.scalar_fitness == 32'sh80000000))
        else $error("saturated flag with an unclipped fitness");

    a_start_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_start || sq_start) |=> !req_ready)
        else $error("request accepted while a unit runs");
`endif

endmodule
`default_nettype wire

/* src/msf_mul.sv */
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module msf_mul
    import msf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [32:0] a,
    input  wire logic signed [31:0] b,
    output logic signed [64:0]      p
);

    logic signed [64:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 65'(a) * 65'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

/* src/msf_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module msf_div
    import msf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        rem_sh = {rem_reg, quo_reg[63]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = 32'(rem_sh - {1'b0, dvs_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

/* src/msf_sqrt.sv */
// bit-pair integer square root, one step per cycle
`timescale 1ns / 1ps
`default_nettype none
module msf_sqrt
    import msf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] x,
    output logic             done,
    output logic [31:0]      root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] rb;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        x_next = x_reg;
        r_next = r_reg;
        b_next = b_reg;
        rb = r_reg + b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            x_next = x;
            r_next = '0;
            b_next = 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (x_reg >= rb)
            begin
                x_next = x_reg - rb;
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule
`default_nettype wire
